### rtl/ipv4_flow_key_extractor_unit_defines.svh
// ----------------------------------------------------------------------------
// ipv4_flow_key_extractor_unit_defines
// assertion macros for the flow key extractor, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef IPV4_FLOW_KEY_EXTRACTOR_UNIT_DEFINES_SVH
`define IPV4_FLOW_KEY_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define IPV4FKE_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ipv4 flow key extractor check failed");

`define IPV4FKE_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ipv4 flow key extractor check failed");

`else

`define IPV4FKE_ASSERT_NOW(label, ck, rs, ante, cons)

`define IPV4FKE_ASSERT_NEXT(label, ck, rs, ante, cons)

`endif

`endif

### rtl/ipv4fke_pkg.sv
// ----------------------------------------------------------------------------
// ipv4fke_pkg
// shared types, header offsets and link tables for the flow key extractor
// ----------------------------------------------------------------------------
package ipv4fke_pkg;

  localparam int unsigned OUT_W       = 144;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LINK_TYPE,
    CFG_PORT_ACCT,
    CFG_NF_DISABLE,
    CFG_NF_SAMPLED,
    CFG_SAMPLE_INTERVAL
  } cfg_index_e;

  typedef enum logic [2:0] {
    LINK_ETHERNET,
    LINK_PPP,
    LINK_RAW,
    LINK_NULL,
    LINK_SLL,
    LINK_TOKEN_RING
  } link_type_e;

  // offsets within the ip header
  localparam logic [15:0] IP_VER_OFS     = 16'd0;
  localparam logic [15:0] IP_TOS_OFS     = 16'd1;
  localparam logic [15:0] IP_LEN_HI_OFS  = 16'd2;
  localparam logic [15:0] IP_LEN_LO_OFS  = 16'd3;
  localparam logic [15:0] IP_PROTO_OFS   = 16'd9;
  localparam logic [15:0] IP_SRC_OFS     = 16'd12;
  localparam logic [15:0] IP_DST_OFS     = 16'd16;
  localparam logic [15:0] IP_HDR_MIN     = 16'd20;
  localparam logic [15:0] L4_PORT_BYTES  = 16'd4;
  localparam logic [15:0] TCP_FLAGS_OFS  = 16'd13;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_SCTP = 8'd132;

  typedef struct packed {
    logic [2:0]  link_type;
    logic        port_accounting;
    logic        netflow_disable;
    logic        netflow_sampled;
    logic [15:0] sample_interval;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [7:0]  ip_protocol;
    logic [7:0]  type_of_service;
    logic        ports_valid;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] ip_length;
  } flow_key_t;

  function automatic logic [4:0] link_offset(input logic [2:0] lt);
    logic [4:0] ofs;
    case (lt)
      LINK_ETHERNET:   ofs = 5'd14;
      LINK_PPP:        ofs = 5'd4;
      LINK_RAW:        ofs = 5'd0;
      LINK_NULL:       ofs = 5'd4;
      LINK_SLL:        ofs = 5'd16;
      LINK_TOKEN_RING: ofs = 5'd22;
      default:         ofs = 5'd0;
    endcase
    return ofs;
  endfunction

  function automatic logic link_supported(input logic [2:0] lt);
    logic ok;
    case (lt)
      LINK_ETHERNET, LINK_PPP, LINK_RAW, LINK_NULL, LINK_SLL, LINK_TOKEN_RING: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic ported_proto(input logic [7:0] p);
    return (p == PROTO_TCP) || (p == PROTO_UDP) || (p == PROTO_SCTP);
  endfunction

endpackage

### rtl/ipv4fke_hdr.sv
// ----------------------------------------------------------------------------
// ipv4fke_hdr
// byte position tracking, ip and transport header latches, key assembly
// ----------------------------------------------------------------------------
module ipv4fke_hdr (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  input  logic [2:0]             link_type,
  output ipv4fke_pkg::flow_key_t key
);

  logic [15:0] byte_position;
  logic [7:0]  version_ihl;
  logic [7:0]  tos_latch;
  logic [15:0] total_length_latch;
  logic [7:0]  protocol_latch;
  logic [31:0] source_latch;
  logic [31:0] dest_latch;
  logic [31:0] port_latch;
  logic [7:0]  flags_latch;

  logic [15:0] byte_position_next;
  logic [7:0]  version_ihl_next;
  logic [7:0]  tos_latch_next;
  logic [15:0] total_length_latch_next;
  logic [7:0]  protocol_latch_next;
  logic [31:0] source_latch_next;
  logic [31:0] dest_latch_next;
  logic [31:0] port_latch_next;
  logic [7:0]  flags_latch_next;

  logic [4:0]  lofs;
  logic        link_ok;
  logic        in_ip;
  logic [15:0] rel;
  logic [15:0] l4;
  logic        l4_ok;
  logic [16:0] cap;
  logic [16:0] ip_cap;
  logic        acc;
  logic        pv;
  logic        fv;

  assign lofs    = ipv4fke_pkg::link_offset(link_type);
  assign link_ok = ipv4fke_pkg::link_supported(link_type);
  assign in_ip   = link_ok && (byte_position >= {11'd0, lofs});
  assign rel     = byte_position - {11'd0, lofs};
  assign l4      = {10'd0, version_ihl[3:0], 2'b00};
  assign l4_ok   = l4 >= ipv4fke_pkg::IP_HDR_MIN;

  always_comb begin
    version_ihl_next        = version_ihl;
    tos_latch_next          = tos_latch;
    total_length_latch_next = total_length_latch;
    protocol_latch_next     = protocol_latch;
    source_latch_next       = source_latch;
    dest_latch_next         = dest_latch;
    port_latch_next         = port_latch;
    flags_latch_next        = flags_latch;
    if (in_ip) begin
      if (rel == ipv4fke_pkg::IP_VER_OFS) begin
        version_ihl_next = data_byte;
      end else if (rel == ipv4fke_pkg::IP_TOS_OFS) begin
        tos_latch_next = data_byte;
      end else if (rel == ipv4fke_pkg::IP_LEN_HI_OFS || rel == ipv4fke_pkg::IP_LEN_LO_OFS) begin
        total_length_latch_next = {total_length_latch[7:0], data_byte};
      end else if (rel == ipv4fke_pkg::IP_PROTO_OFS) begin
        protocol_latch_next = data_byte;
      end else if (rel >= ipv4fke_pkg::IP_SRC_OFS && rel < ipv4fke_pkg::IP_DST_OFS) begin
        source_latch_next = {source_latch[23:0], data_byte};
      end else if (rel >= ipv4fke_pkg::IP_DST_OFS && rel < ipv4fke_pkg::IP_HDR_MIN) begin
        dest_latch_next = {dest_latch[23:0], data_byte};
      end
      if (rel >= ipv4fke_pkg::IP_HDR_MIN && l4_ok) begin
        if (rel >= l4 && rel < l4 + ipv4fke_pkg::L4_PORT_BYTES) begin
          port_latch_next = {port_latch[23:0], data_byte};
        end
        if (rel == l4 + ipv4fke_pkg::TCP_FLAGS_OFS) begin
          flags_latch_next = data_byte;
        end
      end
    end
  end

  always_comb begin
    if (last_byte) begin
      byte_position_next = 16'd0;
    end else if (byte_position != 16'hFFFF) begin
      byte_position_next = byte_position + 16'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
      version_ihl   <= 8'd0;
    end else if (step) begin
      byte_position <= byte_position_next;
      version_ihl   <= version_ihl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tos_latch          <= tos_latch_next;
      total_length_latch <= total_length_latch_next;
      protocol_latch     <= protocol_latch_next;
      source_latch       <= source_latch_next;
      dest_latch         <= dest_latch_next;
      port_latch         <= port_latch_next;
      flags_latch        <= flags_latch_next;
    end
  end

  // key as seen once the current byte is folded in
  assign cap    = {1'b0, byte_position} + 17'd1;
  assign ip_cap = cap - {12'd0, lofs};
  assign acc    = link_ok && (cap >= {12'd0, lofs} + {1'b0, ipv4fke_pkg::IP_HDR_MIN})
                  && (version_ihl_next[7:4] == ipv4fke_pkg::IP_VERSION_4);
  assign pv     = ipv4fke_pkg::ported_proto(protocol_latch_next) && l4_ok
                  && ({1'b0, l4} + {1'b0, ipv4fke_pkg::L4_PORT_BYTES} <= ip_cap);
  assign fv     = pv && (protocol_latch_next == ipv4fke_pkg::PROTO_TCP)
                  && ({1'b0, l4} + {1'b0, ipv4fke_pkg::TCP_FLAGS_OFS} < ip_cap);

  always_comb begin
    key = '0;
    if (acc) begin
      key.accepted        = 1'b1;
      key.source_ip       = source_latch_next;
      key.dest_ip         = dest_latch_next;
      key.ip_protocol     = protocol_latch_next;
      key.type_of_service = tos_latch_next;
      key.ports_valid     = pv;
      key.source_port     = pv ? port_latch_next[31:16] : 16'd0;
      key.dest_port       = pv ? port_latch_next[15:0] : 16'd0;
      key.tcp_flag_bits   = fv ? flags_latch_next : 8'd0;
      key.ip_length       = total_length_latch_next;
    end
  end

endmodule

### rtl/ipv4_flow_key_extractor_unit.sv
// ----------------------------------------------------------------------------
// ipv4_flow_key_extractor_unit
// per-byte ipv4 five-tuple extraction with optional 1-in-n sampling
// ----------------------------------------------------------------------------
// throughput: one byte per cycle, set by the single header update stage,
// while the result register is free; a last byte waits in the input stage
// one result per packet, on the byte marked by s_tlast
// reset (rst, synchronous): registers return to their reset values,
// sample phase and byte position clear, input and output stages empty
`include "ipv4_flow_key_extractor_unit_defines.svh"

module ipv4_flow_key_extractor_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,   // data_byte
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // accepted, flow_emit, source_ip, dest_ip, ip_protocol, type_of_service,
  // ports_valid, source_port, dest_port, tcp_flag_bits, ip_length,
  // aggregate_ports, zero pad
  output logic [ipv4fke_pkg::OUT_W-1:0]         m_tdata,
  input  logic                                  cfg_we,
  input  logic [ipv4fke_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ipv4fke_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ipv4fke_pkg::cfg_t      cfg;
  ipv4fke_pkg::flow_key_t key;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_go;

  logic [15:0] sample_phase;
  logic [15:0] sample_phase_next;
  logic [16:0] phase_inc;
  logic [16:0] interval_eff;
  logic        sample_step;
  logic        emit;
  logic        aggregate;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_type       <= 3'd0;
      cfg.port_accounting <= 1'b0;
      cfg.netflow_disable <= 1'b0;
      cfg.netflow_sampled <= 1'b0;
      cfg.sample_interval <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        ipv4fke_pkg::CFG_LINK_TYPE:       cfg.link_type       <= cfg_data[2:0];
        ipv4fke_pkg::CFG_PORT_ACCT:       cfg.port_accounting <= cfg_data[0];
        ipv4fke_pkg::CFG_NF_DISABLE:      cfg.netflow_disable <= cfg_data[0];
        ipv4fke_pkg::CFG_NF_SAMPLED:      cfg.netflow_sampled <= cfg_data[0];
        ipv4fke_pkg::CFG_SAMPLE_INTERVAL: cfg.sample_interval <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input stage; a last byte waits only for a free result slot
  assign s1_go    = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  ipv4fke_hdr u_hdr (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .link_type (cfg.link_type),
    .key       (key)
  );

  // sampling phase
  assign sample_step  = s1_go && s1_last && key.accepted && !cfg.netflow_disable
                        && cfg.netflow_sampled;
  assign phase_inc    = {1'b0, sample_phase} + 17'd1;
  assign interval_eff = (cfg.sample_interval == 16'd0) ? 17'd1 : {1'b0, cfg.sample_interval};
  assign sample_phase_next = (phase_inc >= interval_eff) ? 16'd0 : phase_inc[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_phase <= 16'd0;
    end else if (sample_step) begin
      sample_phase <= sample_phase_next;
    end
  end

  assign emit      = key.accepted && !cfg.netflow_disable
                     && (!cfg.netflow_sampled || sample_phase == 16'd0);
  assign aggregate = key.accepted && !cfg.port_accounting;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      m_tdata <= {4'd0, aggregate, key.ip_length, key.tcp_flag_bits, key.dest_port,
                  key.source_port, key.ports_valid, key.type_of_service, key.ip_protocol,
                  key.dest_ip, key.source_ip, emit, key.accepted};
    end
  end

  `IPV4FKE_ASSERT_NOW(a_emit_needs_accept, clk, rst, m_tvalid && m_tdata[1], m_tdata[0])
  `IPV4FKE_ASSERT_NOW(a_reject_is_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[143:1] == '0)
  `IPV4FKE_ASSERT_NOW(a_stall_has_byte, clk, rst, !s_tready, s1_valid && s1_last && m_tvalid)
  `IPV4FKE_ASSERT_NEXT(a_last_gives_result, clk, rst, s1_go && s1_last, m_tvalid)

endmodule
